// ----- rtl/core/tips_pkg.sv -----
// shared constants, types and helpers for the time indexed packet store
package tips_pkg;

   // sizing of the store
   localparam int PACKETS_PER_BLOCK = 64;
   localparam int MAX_BLOCKS        = 256;
   localparam int TAG_BITS          = 32;

   // fixed field widths of the request and response
   localparam int FUNC_W      = 1;
   localparam int SEC_W       = 32;
   localparam int USEC_W      = 20;
   localparam int TIME_W      = SEC_W + USEC_W;
   localparam int STATUS_W    = 2;
   localparam int BLOCK_OUT_W = 8;
   localparam int SLOT_OUT_W  = 6;
   localparam int FOUND_TAG_W = 32;

   // derived widths
   localparam int PKT_DEPTH = MAX_BLOCKS * PACKETS_PER_BLOCK;
   localparam int SLOT_W    = $clog2(PACKETS_PER_BLOCK);
   localparam int BLK_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ADDR_W    = $clog2(PKT_DEPTH);
   localparam int SCNT_W    = $clog2(PACKETS_PER_BLOCK + 1);
   localparam int BCNT_W    = $clog2(MAX_BLOCKS + 1);

   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [BLK_W-1:0]    blk_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [SCNT_W-1:0]   scnt_type;
   typedef logic [BCNT_W-1:0]   bcnt_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // write and read controls toward the storage
   typedef struct packed {
      logic     pkt_we;
      addr_type pkt_waddr;
      time_type pkt_wtime;
      tag_type  pkt_wtag;
      addr_type pkt_raddr;
      logic     first_we;
      logic     last_we;
      blk_type  blk_waddr;
      time_type blk_wtime;
      blk_type  blk_raddr;
   } mem_req_type;

   // registered read data from the storage
   typedef struct packed {
      time_type pkt_time;
      tag_type  pkt_tag;
      time_type blk_first;
      time_type blk_last;
   } mem_rsp_type;

   // flat slot address of a packet
   function automatic addr_type pkt_addr(blk_type b, slot_type s);
      addr_type a;
      a = addr_type'(addr_type'(b) * addr_type'(PACKETS_PER_BLOCK) + addr_type'(s));
      return a;
   endfunction

endpackage

// ----- rtl/core/tips_req_if.sv -----
// request channel of the packet store
interface tips_req_if;
   import tips_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SEC_W-1:0]    ts_sec;
   logic [USEC_W-1:0]   ts_usec;
   logic [TAG_BITS-1:0] packet_tag;

   modport source (output valid, func, ts_sec, ts_usec, packet_tag, input ready);
   modport sink   (input valid, func, ts_sec, ts_usec, packet_tag, output ready);
endinterface

// ----- rtl/core/tips_rsp_if.sv -----
// response channel of the packet store
interface tips_rsp_if;
   import tips_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [BLOCK_OUT_W-1:0] block_number;
   logic [SLOT_OUT_W-1:0]  slot_number;
   logic [FOUND_TAG_W-1:0] found_tag;

   modport source (output valid, status, block_number, slot_number, found_tag, input ready);
   modport sink   (input valid, status, block_number, slot_number, found_tag, output ready);
endinterface

// ----- rtl/core/tips_mem.sv -----
// packet and block-range storage, registered reads
module tips_mem (
   input  logic                  clock,
   input  tips_pkg::mem_req_type mem_req,
   output tips_pkg::mem_rsp_type mem_rsp
);
   import tips_pkg::*;

   time_type pkt_time_mem  [0:PKT_DEPTH-1];
   tag_type  pkt_tag_mem   [0:PKT_DEPTH-1];
   time_type blk_first_mem [0:MAX_BLOCKS-1];
   time_type blk_last_mem  [0:MAX_BLOCKS-1];

   time_type pkt_time_ff;
   tag_type  pkt_tag_ff;
   time_type blk_first_ff;
   time_type blk_last_ff;

   // packet slots
   always_ff @(posedge clock) begin
      if (mem_req.pkt_we) begin
         pkt_time_mem[mem_req.pkt_waddr] <= mem_req.pkt_wtime;
         pkt_tag_mem[mem_req.pkt_waddr]  <= mem_req.pkt_wtag;
      end
      pkt_time_ff <= pkt_time_mem[mem_req.pkt_raddr];
      pkt_tag_ff  <= pkt_tag_mem[mem_req.pkt_raddr];
   end

   // block first and last times
   always_ff @(posedge clock) begin
      if (mem_req.first_we) begin
         blk_first_mem[mem_req.blk_waddr] <= mem_req.blk_wtime;
      end
      if (mem_req.last_we) begin
         blk_last_mem[mem_req.blk_waddr] <= mem_req.blk_wtime;
      end
      blk_first_ff <= blk_first_mem[mem_req.blk_raddr];
      blk_last_ff  <= blk_last_mem[mem_req.blk_raddr];
   end

   assign mem_rsp.pkt_time  = pkt_time_ff;
   assign mem_rsp.pkt_tag   = pkt_tag_ff;
   assign mem_rsp.blk_first = blk_first_ff;
   assign mem_rsp.blk_last  = blk_last_ff;
endmodule

// ----- rtl/core/time_indexed_packet_store.sv -----
// Time indexed packet store: packets (time and tag) are appended into fixed
// blocks of PACKETS_PER_BLOCK slots, up to MAX_BLOCKS blocks, and found again
// by time. An append's result passes through S_RESP into the output register,
// with status full once every block is full. A lookup binary-searches the
// block ranges, then the chosen block, and returns the exact match or the
// last earlier packet, or status not_found. Each search probe has a read
// state, S_BRD or S_SRD, for the synchronous read of block or packet memory
// and a compare state, S_BCMP or S_SCMP. On an exact match the compare state
// goes to S_RESP; when no block holds the time, S_BRD goes to S_RESP; the last
// earlier packet is read through S_TRD and S_TWAIT before S_RESP. A search has
// at most 9 block and 7 slot probes with 256 blocks of 64 packets. The next
// request can be taken in the same cycle as the
// response turns valid. A request is taken only while the controller is idle;
// a finished response waits in the output register without holding up the
// next request. Memories need no clearing after reset: only written entries
// are ever searched.
module time_indexed_packet_store (
   input  logic clock,
   input  logic reset,
   tips_req_if.sink   req_chan,
   tips_rsp_if.source rsp_chan
);
   import tips_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_BRD   = 8'b0000_0010,
      S_BCMP  = 8'b0000_0100,
      S_SRD   = 8'b0000_1000,
      S_SCMP  = 8'b0001_0000,
      S_TRD   = 8'b0010_0000,
      S_TWAIT = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   bcnt_type    blocks_used_ff, blocks_used_in;
   scnt_type    fill_ff, fill_in;
   time_type    target_ff, target_in;
   bcnt_type    blo_ff, blo_in, bhi_ff, bhi_in;
   scnt_type    slo_ff, slo_in, shi_ff, shi_in;
   blk_type     found_ff, found_in;
   slot_type    slot_ff, slot_in;
   status_type  res_status_ff, res_status_in;
   blk_type     res_blk_ff, res_blk_in;
   slot_type    res_slot_ff, res_slot_in;
   tag_type     res_tag_ff, res_tag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   blk_type     rsp_blk_ff, rsp_blk_in;
   slot_type    rsp_slot_ff, rsp_slot_in;
   tag_type     rsp_tag_ff, rsp_tag_in;

   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   logic        req_fire;
   time_type    req_time;
   logic        new_blk;
   blk_type     app_blk;
   slot_type    app_slot;
   logic [BCNT_W:0] bsum;
   logic [SCNT_W:0] ssum;
   blk_type     bmid;
   slot_type    smid;
   scnt_type    blk_count;
   slot_type    rd_slot;

   tips_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   // handshake and request decode
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_time       = {req_chan.ts_sec, req_chan.ts_usec};

   // append placement
   assign new_blk  = (blocks_used_ff == '0) ||
                     (fill_ff >= scnt_type'(PACKETS_PER_BLOCK));
   assign app_blk  = new_blk ? blk_type'(blocks_used_ff) : blk_type'(blocks_used_ff - 1'b1);
   assign app_slot = new_blk ? '0 : slot_type'(fill_ff);

   // search midpoints
   assign bsum = (BCNT_W + 1)'(blo_ff) + (BCNT_W + 1)'(bhi_ff) - 1'b1;
   assign bmid = blk_type'(bsum >> 1);
   assign ssum = (SCNT_W + 1)'(slo_ff) + (SCNT_W + 1)'(shi_ff) - 1'b1;
   assign smid = slot_type'(ssum >> 1);

   // packets in the chosen block: the current block may be partly filled
   assign blk_count = ((BCNT_W'(bmid) + 1'b1) == blocks_used_ff) ? fill_ff
                      : scnt_type'(PACKETS_PER_BLOCK);

   assign rd_slot = (state_ff == S_TRD) ? slot_ff : smid;

   // memory controls
   always_comb begin
      mem_req           = '0;
      mem_req.pkt_waddr = pkt_addr(app_blk, app_slot);
      mem_req.pkt_wtime = req_time;
      mem_req.pkt_wtag  = req_chan.packet_tag;
      mem_req.pkt_raddr = pkt_addr(found_ff, rd_slot);
      mem_req.blk_waddr = app_blk;
      mem_req.blk_wtime = req_time;
      mem_req.blk_raddr = bmid;
      if (req_fire && (func_type'(req_chan.func) == FUNC_APPEND) &&
          !(new_blk && (blocks_used_ff >= bcnt_type'(MAX_BLOCKS)))) begin
         mem_req.pkt_we   = 1'b1;
         mem_req.first_we = new_blk;
         mem_req.last_we  = 1'b1;
      end
   end

   // controller
   always_comb begin
      state_in       = state_ff;
      blocks_used_in = blocks_used_ff;
      fill_in        = fill_ff;
      target_in      = target_ff;
      blo_in         = blo_ff;
      bhi_in         = bhi_ff;
      slo_in         = slo_ff;
      shi_in         = shi_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      res_status_in  = res_status_ff;
      res_blk_in     = res_blk_ff;
      res_slot_in    = res_slot_ff;
      res_tag_in     = res_tag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_blk_in     = rsp_blk_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_tag_in     = rsp_tag_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (func_type'(req_chan.func) == FUNC_APPEND) begin
                  state_in   = S_RESP;
                  res_tag_in = '0;
                  if (new_blk && (blocks_used_ff >= bcnt_type'(MAX_BLOCKS))) begin
                     res_status_in = STATUS_FULL;
                     res_blk_in    = '0;
                     res_slot_in   = '0;
                  end else begin
                     res_status_in  = STATUS_OK;
                     res_blk_in     = app_blk;
                     res_slot_in    = app_slot;
                     blocks_used_in = blocks_used_ff + bcnt_type'(new_blk);
                     fill_in        = new_blk ? scnt_type'(1) : fill_ff + 1'b1;
                  end
               end else begin
                  state_in  = S_BRD;
                  target_in = req_time;
                  blo_in    = '0;
                  bhi_in    = blocks_used_ff;
               end
            end
         end
         // block range probe: issue read or give up
         S_BRD: begin
            if (blo_ff < bhi_ff) begin
               state_in = S_BCMP;
            end else begin
               state_in      = S_RESP;
               res_status_in = STATUS_NOT_FOUND;
               res_blk_in    = '0;
               res_slot_in   = '0;
               res_tag_in    = '0;
            end
         end
         S_BCMP: begin
            priority if (target_ff < mem_rsp.blk_first) begin
               bhi_in   = bcnt_type'(bmid);
               state_in = S_BRD;
            end else if (target_ff > mem_rsp.blk_last) begin
               blo_in   = bcnt_type'(bmid) + 1'b1;
               state_in = S_BRD;
            end else begin
               found_in = bmid;
               slo_in   = '0;
               shi_in   = blk_count;
               state_in = S_SRD;
            end
         end
         // slot probe: issue read or settle on the last earlier packet
         S_SRD: begin
            if (slo_ff < shi_ff) begin
               state_in = S_SCMP;
            end else begin
               slot_in  = (shi_ff == '0) ? '0 : slot_type'(shi_ff - 1'b1);
               state_in = S_TRD;
            end
         end
         S_SCMP: begin
            priority if (target_ff < mem_rsp.pkt_time) begin
               shi_in   = scnt_type'(smid);
               state_in = S_SRD;
            end else if (target_ff > mem_rsp.pkt_time) begin
               slo_in   = scnt_type'(smid) + 1'b1;
               state_in = S_SRD;
            end else begin
               res_status_in = STATUS_OK;
               res_blk_in    = found_ff;
               res_slot_in   = smid;
               res_tag_in    = mem_rsp.pkt_tag;
               state_in      = S_RESP;
            end
         end
         S_TRD: begin
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            res_status_in = STATUS_OK;
            res_blk_in    = found_ff;
            res_slot_in   = slot_ff;
            res_tag_in    = mem_rsp.pkt_tag;
            state_in      = S_RESP;
         end
         // hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_blk_in    = res_blk_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_tag_in    = res_tag_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         blocks_used_ff <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         blocks_used_ff <= blocks_used_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // search and result registers
   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      blo_ff        <= blo_in;
      bhi_ff        <= bhi_in;
      slo_ff        <= slo_in;
      shi_ff        <= shi_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_blk_ff    <= res_blk_in;
      res_slot_ff   <= res_slot_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   // response port
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.block_number = BLOCK_OUT_W'(rsp_blk_ff);
   assign rsp_chan.slot_number  = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_chan.found_tag    = FOUND_TAG_W'(rsp_tag_ff);
endmodule

// ----- rtl/core/tips_chk.sv -----
// port-level checks of the packet store, bound to the top level
module tips_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tips_pkg::STATUS_W-1:0]    rsp_status,
   input logic [tips_pkg::BLOCK_OUT_W-1:0] rsp_block_number,
   input logic [tips_pkg::SLOT_OUT_W-1:0]  rsp_slot_number,
   input logic [tips_pkg::FOUND_TAG_W-1:0] rsp_found_tag
);
   import tips_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_block_number) && $stable(rsp_slot_number) && $stable(rsp_found_tag))
      else $error("response changed while stalled");

   // one request at a time: busy right after taking one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // failed requests report zero position and tag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         rsp_block_number == '0 && rsp_slot_number == '0 && rsp_found_tag == '0)
      else $error("failed response carries nonzero fields");

   // no response code outside ok, full and not found
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_FULL) ||
         (rsp_status == STATUS_NOT_FOUND))
      else $error("bad response status");

   // a response never appears the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early");
endmodule

bind time_indexed_packet_store tips_chk u_tips_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_block_number (rsp_chan.block_number),
   .rsp_slot_number  (rsp_chan.slot_number),
   .rsp_found_tag    (rsp_chan.found_tag)
);

// ----- sim/time_indexed_packet_store_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the time indexed packet store: appends and time lookups
module time_indexed_packet_store_tb;
   import tips_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      status_type             status;
      logic [BLOCK_OUT_W-1:0] block;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [FOUND_TAG_W-1:0] tag;
   } store_reply_type;

   logic clock = 1'b0;
   logic reset;
   logic reply_ready = 1'b0;

   tips_req_if req_bus ();
   tips_rsp_if rsp_bus ();

   assign rsp_bus.ready = reply_ready;

   time_indexed_packet_store u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the store contents
   time_type slot_time [PKT_DEPTH];
   tag_type  slot_tag [PKT_DEPTH];
   time_type first_of_block [MAX_BLOCKS];
   time_type last_of_block [MAX_BLOCKS];
   int       n_blocks = 0;
   int       n_filled = 0;

   store_reply_type owed_replies [$];
   int              mismatches = 0;
   int              send_gap_pct = 0;
   int              recv_stall_pct = 0;
   int              quiet_cycles = 0;

   // time of the latest in-order append
   logic [SEC_W-1:0] cur_sec;
   int               cur_usec;

   function automatic int packets_written();
      return (n_blocks == 0) ? 0 : (n_blocks - 1) * PACKETS_PER_BLOCK + n_filled;
   endfunction

   // store one packet, opening a new block when needed
   function automatic store_reply_type append_packet(time_type t, tag_type tag);
      store_reply_type r;
      int              b;
      int              s;
      r = '0;
      if (n_blocks == 0 || n_filled >= PACKETS_PER_BLOCK) begin
         if (n_blocks >= MAX_BLOCKS) begin
            r.status = STATUS_FULL;
            return r;
         end
         first_of_block[n_blocks] = t;
         n_blocks++;
         n_filled = 0;
      end
      b = n_blocks - 1;
      s = n_filled;
      slot_time[b * PACKETS_PER_BLOCK + s] = t;
      slot_tag[b * PACKETS_PER_BLOCK + s] = tag;
      last_of_block[b] = t;
      n_filled++;
      r.status = STATUS_OK;
      r.block = BLOCK_OUT_W'(b);
      r.slot = SLOT_OUT_W'(s);
      return r;
   endfunction

   // search block ranges, then the chosen block; exact match or last earlier slot
   function automatic store_reply_type find_packet(time_type t);
      store_reply_type r;
      int              lo;
      int              hi;
      int              mid;
      int              found;
      int              slot;
      int              count;
      int              base;
      r = '0;
      lo = 0;
      hi = n_blocks - 1;
      found = -1;
      slot = -1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (t < first_of_block[mid]) hi = mid - 1;
         else if (t > last_of_block[mid]) lo = mid + 1;
         else begin
            found = mid;
            break;
         end
      end
      if (found < 0) begin
         r.status = STATUS_NOT_FOUND;
         return r;
      end
      count = (found == n_blocks - 1) ? n_filled : PACKETS_PER_BLOCK;
      base = found * PACKETS_PER_BLOCK;
      lo = 0;
      hi = count - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (t < slot_time[base + mid]) hi = mid - 1;
         else if (t > slot_time[base + mid]) lo = mid + 1;
         else begin
            slot = mid;
            break;
         end
      end
      if (slot < 0) slot = (hi < 0) ? 0 : hi;
      r.status = STATUS_OK;
      r.block = BLOCK_OUT_W'(found);
      r.slot = SLOT_OUT_W'(slot);
      r.tag = FOUND_TAG_W'(slot_tag[base + slot]);
      return r;
   endfunction

   // move the append time forward: repeats, small and large steps
   function automatic void advance_clock_time(bit allow_jump);
      case ($urandom_range(9))
         0, 1: ;
         2, 3, 4, 5, 6: cur_usec += $urandom_range(1, 250000);
         7: cur_usec += $urandom_range(1, 20);
         8: begin
            cur_sec += $urandom_range(1, 3);
            cur_usec = $urandom_range(0, 999999);
         end
         default: begin
            if (allow_jump) cur_sec += $urandom_range(4, 65536);
            else cur_usec += 1;
         end
      endcase
      if (cur_usec > 999999) begin
         cur_usec -= 1000000;
         cur_sec++;
      end
   endfunction

   // lookup target near stored packets, past the end, or anywhere
   function automatic time_type pick_target();
      time_type base;
      int       count;
      count = packets_written();
      if (count == 0) return {$urandom(), USEC_W'($urandom())};
      base = slot_time[$urandom_range(0, count - 1)];
      case ($urandom_range(9))
         0, 1, 2, 3: return base;
         4, 5: return base + time_type'($urandom_range(1, 50000));
         6: return base - time_type'($urandom_range(1, 50000));
         7: return {cur_sec, USEC_W'(cur_usec)} + time_type'($urandom_range(1, 3000000));
         8: return {$urandom(), USEC_W'($urandom_range(0, 999999))};
         default: return {$urandom(), USEC_W'($urandom())};
      endcase
   endfunction

   // drive one request and record its reply once taken
   task automatic send_request(func_type f, logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec,
                               tag_type tag);
      time_type t;
      t = {sec, usec};
      if ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.ts_sec <= sec;
      req_bus.ts_usec <= usec;
      req_bus.packet_tag <= tag;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (f == FUNC_APPEND) owed_replies.push_back(append_packet(t, tag));
      else owed_replies.push_back(find_packet(t));
   endtask

   task automatic append_at(logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec, tag_type tag);
      send_request(FUNC_APPEND, sec, usec, tag);
   endtask

   // tag is ignored on lookup, so it carries noise
   task automatic lookup_at(time_type t);
      send_request(FUNC_LOOKUP, t[TIME_W-1:USEC_W], t[USEC_W-1:0], $urandom());
   endtask

   task automatic test_empty_store();
      lookup_at('0);
      lookup_at('1);
   endtask

   // field extremes, repeated times, out-of-range microseconds, miss and not-found
   task automatic test_directed_cases();
      append_at(32'd0, 20'd0, 32'h0000_0000);
      append_at(32'd0, 20'd0, 32'hFFFF_FFFF);
      append_at(32'd0, 20'd1, 32'hA5A5_A5A5);
      append_at(32'd1, 20'd999999, 32'h5A5A_5A5A);
      append_at(32'd1, 20'hFFFFF, 32'h0000_0001);
      append_at(32'd2, 20'd0, $urandom());
      lookup_at({32'd0, 20'd0});
      lookup_at({32'd0, 20'd1});
      lookup_at({32'd1, 20'd999999});
      lookup_at({32'd1, 20'd500000});
      lookup_at({32'd1, 20'hFFFFF});
      lookup_at({32'd2, 20'd0});
      lookup_at({32'd2, 20'd1});
      lookup_at('1);
      cur_sec = 32'd2;
      cur_usec = 0;
   endtask

   // mostly ordered appends and lookups, a little out-of-range and out-of-order noise
   task automatic test_random_traffic(int n_items);
      int       r;
      time_type t;
      repeat (n_items) begin
         r = $urandom_range(99);
         if (packets_written() == 0 || r < 47) begin
            advance_clock_time(1'b1);
            append_at(cur_sec, USEC_W'(cur_usec), $urandom());
         end else if (r < 49) begin
            append_at(cur_sec, USEC_W'($urandom_range(1000000, 20'hFFFFF)), $urandom());
            cur_sec++;
            cur_usec = 0;
         end else if (r < 50) begin
            t = slot_time[$urandom_range(0, packets_written() - 1)]
                - time_type'($urandom_range(0, 3));
            append_at(t[TIME_W-1:USEC_W], t[USEC_W-1:0], $urandom());
         end else begin
            lookup_at(pick_target());
         end
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   // reply side: random stall, compare against the oldest outstanding reply
   always @(posedge clock) begin : reply_check
      store_reply_type want;
      reply_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_bus.valid === 1'b1 && reply_ready === 1'b1) begin
         if (owed_replies.size() == 0) begin
            mismatches++;
            $display("%0t: reply expected none got status %0h block %0h slot %0h tag %0h",
                     $time, rsp_bus.status, rsp_bus.block_number, rsp_bus.slot_number,
                     rsp_bus.found_tag);
         end else begin
            want = owed_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
            compare_field("block_number", 32'(want.block), 32'(rsp_bus.block_number));
            compare_field("slot_number", 32'(want.slot), 32'(rsp_bus.slot_number));
            compare_field("found_tag", 32'(want.tag), 32'(rsp_bus.found_tag));
         end
      end
   end

   // watchdog on cycles with no request or reply taken
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_APPEND;
      req_bus.ts_sec <= '0;
      req_bus.ts_usec <= '0;
      req_bus.packet_tag <= '0;
      cur_sec = '0;
      cur_usec = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_directed_cases();
      send_gap_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(175);
      send_gap_pct = 78;
      recv_stall_pct = 0;
      test_random_traffic(175);
      send_gap_pct = 0;
      recv_stall_pct = 78;
      test_random_traffic(175);
      send_gap_pct = 8;
      recv_stall_pct = 8;
      test_random_traffic(175);

      req_bus.valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tips_pkg.sv
rtl/core/tips_req_if.sv
rtl/core/tips_rsp_if.sv
rtl/core/tips_mem.sv
rtl/core/time_indexed_packet_store.sv
rtl/core/tips_chk.sv
sim/time_indexed_packet_store_tb.sv
